// ----- hw/rtl/acm_pkg.sv -----
`default_nettype none

package acm_pkg;

    // field widths
    localparam int PIX_W      = 8;
    localparam int RGB_W      = 3 * PIX_W;
    localparam int ABS_W      = 10;
    localparam int CNT_W      = 8;
    localparam int COST_W     = 15;
    localparam int LAMBDA_W   = 16;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 40;
    localparam int M_USED_W   = COST_W + ABS_W + CNT_W;

    // configuration registers
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_LAMBDA_AD     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_LAMBDA_CENSUS = 4'd1;
    localparam logic [LAMBDA_W-1:0] INV_LAMBDA_AD_RESET     = 16'd6554;
    localparam logic [LAMBDA_W-1:0] INV_LAMBDA_CENSUS_RESET = 16'd2185;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // fixed point exponential
    localparam int FRAC_W        = 30;
    localparam int WORD_W        = FRAC_W + 1;
    localparam int PROD_W        = 2 * WORD_W;
    localparam int X_W           = 26;
    localparam int X_FRAC_W      = 16;
    localparam int X_INT_W       = X_W - X_FRAC_W;
    localparam int IDX_W         = 4;
    localparam int SUM16_W       = 16;
    localparam logic [WORD_W-1:0]  ONE_Q30       = 31'h4000_0000;
    localparam logic [IDX_W-1:0]   SERIES_TERMS  = 4'd12;
    localparam logic [X_INT_W-1:0] EXP_INT_LIMIT = 10'd12;
    localparam logic [IDX_W-1:0]   AD_DIVISOR    = 4'd3;
    localparam logic [SUM16_W-1:0] ONE_Q14       = 16'd16384;
    localparam logic [SUM16_W-1:0] COST_MAX      = 16'd32767;

    // division by a small divisor through a reciprocal multiply
    localparam int RECIP_SHIFT  = 33;
    localparam int RECIP_W      = 33;
    localparam int RECIP_PROD_W = WORD_W + RECIP_W;

    typedef struct packed {
        logic [ABS_W-1:0] abs_sum;
        logic [CNT_W-1:0] count;
    } cost_job_t;

    typedef struct packed {
        logic [LAMBDA_W-1:0] inv_lambda_ad;
        logic [LAMBDA_W-1:0] inv_lambda_census;
    } cost_cfg_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SER_MUL,
        BK_SER_DGO,
        BK_SER_DWAIT,
        BK_X_MUL,
        BK_X_DGO,
        BK_X_DWAIT,
        BK_X_EVAL,
        BK_POW,
        BK_TERM,
        BK_OUT
    } back_state_t;

    typedef enum logic [1:0] {
        PH_E1,
        PH_AD,
        PH_CEN
    } phase_t;

endpackage

`default_nettype wire

// ----- hw/rtl/acm_queue.sv -----
`default_nettype none

module acm_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire acm_pkg::cost_job_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   pop_valid,
    output acm_pkg::cost_job_t     pop_data
);

    acm_pkg::cost_job_t entry_reg [acm_pkg::QUEUE_DEPTH];
    logic [acm_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [acm_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [acm_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == acm_pkg::QCNT_W'(acm_pkg::QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == acm_pkg::QPTR_W'(acm_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == acm_pkg::QPTR_W'(acm_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> pop_valid)
        else $error("job popped from empty queue");

endmodule

`default_nettype wire

// ----- hw/rtl/acm_front.sv -----
`default_nettype none

module acm_front #(
    parameter int MAX_WINDOW_PIXELS = 81
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [acm_pkg::S_TDATA_W-1:0] in_data,
    input  wire logic                          in_first,
    input  wire logic                          in_last,
    input  wire logic                          queue_full,
    output logic                               push,
    output acm_pkg::cost_job_t                 push_data
);

    localparam int BOUND_RAW = 3 * MAX_WINDOW_PIXELS;
    localparam int BOUND_INT = (BOUND_RAW > 255) ? 255 : BOUND_RAW;
    localparam logic [acm_pkg::CNT_W:0] BOUND = (acm_pkg::CNT_W + 1)'(BOUND_INT);

    logic [acm_pkg::RGB_W-1:0] ref_l_reg, ref_l_next;
    logic [acm_pkg::RGB_W-1:0] ref_r_reg, ref_r_next;
    logic [acm_pkg::ABS_W-1:0] abs_reg, abs_next;
    logic [acm_pkg::CNT_W-1:0] count_reg, count_next;

    logic [acm_pkg::RGB_W-1:0] left_pix, right_pix;
    logic [acm_pkg::ABS_W-1:0] centre_sum;
    logic [1:0]                opp_cnt;
    logic [acm_pkg::CNT_W:0]   count_sum;
    logic                      accept;

    assign left_pix  = in_data[acm_pkg::RGB_W-1:0];
    assign right_pix = in_data[2*acm_pkg::RGB_W-1:acm_pkg::RGB_W];
    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;

    // centre abs difference sum and opposite-side channel count
    always_comb begin
        logic [acm_pkg::PIX_W-1:0] l, r, lr, rr;
        centre_sum = '0;
        opp_cnt    = '0;
        for (int c = 0; c < 3; c++) begin
            l  = left_pix[c*acm_pkg::PIX_W +: acm_pkg::PIX_W];
            r  = right_pix[c*acm_pkg::PIX_W +: acm_pkg::PIX_W];
            lr = ref_l_reg[c*acm_pkg::PIX_W +: acm_pkg::PIX_W];
            rr = ref_r_reg[c*acm_pkg::PIX_W +: acm_pkg::PIX_W];
            centre_sum = centre_sum + acm_pkg::ABS_W'((l > r) ? (l - r) : (r - l));
            if ((l < lr && r > rr) || (l > lr && r < rr)) begin
                opp_cnt = opp_cnt + 1'b1;
            end
        end
        count_sum = {1'b0, count_reg} + (acm_pkg::CNT_W + 1)'(opp_cnt);
    end

    // group state; the centre pair ties with itself so it adds nothing
    always_comb begin
        ref_l_next = ref_l_reg;
        ref_r_next = ref_r_reg;
        abs_next   = abs_reg;
        count_next = count_reg;
        if (accept) begin
            if (in_first) begin
                ref_l_next = left_pix;
                ref_r_next = right_pix;
                abs_next   = centre_sum;
                count_next = '0;
            end else begin
                count_next = (count_sum > BOUND) ? BOUND[acm_pkg::CNT_W-1:0] :
                             count_sum[acm_pkg::CNT_W-1:0];
            end
        end
        push              = accept && in_last;
        push_data.abs_sum = abs_next;
        push_data.count   = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_l_reg <= '0;
            ref_r_reg <= '0;
            abs_reg   <= '0;
            count_reg <= '0;
        end else begin
            ref_l_reg <= ref_l_next;
            ref_r_reg <= ref_r_next;
            abs_reg   <= abs_next;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, count_reg} <= BOUND)
        else $error("mismatch count above its bound");

endmodule

`default_nettype wire

// ----- hw/rtl/acm_div.sv -----
`default_nettype none

module acm_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [acm_pkg::WORD_W-1:0] dividend,
    input  wire logic [acm_pkg::IDX_W-1:0]  divisor,
    output logic                            done,
    output logic [acm_pkg::WORD_W-1:0]      quotient
);

    logic [acm_pkg::RECIP_W-1:0]      recip;
    logic [acm_pkg::RECIP_PROD_W-1:0] prod;
    logic [acm_pkg::WORD_W-1:0]       quot_reg, quot_next;
    logic                             done_reg, done_next;

    assign done     = done_reg;
    assign quotient = quot_reg;

    // ceil(2^33 / d); the floor is exact for dividends up to 2^30
    always_comb begin
        unique case (divisor)
            4'd2:    recip = 33'h1_0000_0000;
            4'd3:    recip = 33'h0_AAAA_AAAB;
            4'd4:    recip = 33'h0_8000_0000;
            4'd5:    recip = 33'h0_6666_6667;
            4'd6:    recip = 33'h0_5555_5556;
            4'd7:    recip = 33'h0_4924_924A;
            4'd8:    recip = 33'h0_4000_0000;
            4'd9:    recip = 33'h0_38E3_8E39;
            4'd10:   recip = 33'h0_3333_3334;
            4'd11:   recip = 33'h0_2E8B_A2E9;
            4'd12:   recip = 33'h0_2AAA_AAAB;
            default: recip = '0;
        endcase
    end

    // one multiply per division; the result is registered and ready in the cycle after start
    always_comb begin
        prod      = acm_pkg::RECIP_PROD_W'(dividend) * acm_pkg::RECIP_PROD_W'(recip);
        quot_next = quot_reg;
        done_next = start;
        if (start) begin
            quot_next = (divisor == acm_pkg::IDX_W'(1)) ? dividend :
                        prod[acm_pkg::RECIP_SHIFT +: acm_pkg::WORD_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
    end

    a_done_follows_start: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> done)
        else $error("division result missing after start");

    a_dividend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (dividend <= acm_pkg::ONE_Q30))
        else $error("dividend outside the exact reciprocal range");

endmodule

`default_nettype wire

// ----- hw/rtl/acm_back.sv -----
`default_nettype none

module acm_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire acm_pkg::cost_cfg_t         cfg,
    input  wire logic                       job_valid,
    input  wire acm_pkg::cost_job_t         job_data,
    output logic                            job_pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [acm_pkg::COST_W-1:0]      out_cost,
    output logic [acm_pkg::ABS_W-1:0]       out_abs,
    output logic [acm_pkg::CNT_W-1:0]       out_count
);

    localparam int WW = acm_pkg::WORD_W;
    localparam int FW = acm_pkg::FRAC_W;

    acm_pkg::back_state_t state_reg, state_next;
    acm_pkg::phase_t      phase_reg, phase_next;

    logic [acm_pkg::ABS_W-1:0]   abs_reg, abs_next;
    logic [acm_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [WW-1:0]               y_reg, y_next;
    logic [WW-1:0]               term_reg, term_next;
    logic [WW-1:0]               sum_reg, sum_next;
    logic [acm_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [WW-1:0]               e1_reg, e1_next;
    logic [WW-1:0]               e_reg, e_next;
    logic [acm_pkg::X_W-1:0]     x_reg, x_next;
    logic [acm_pkg::IDX_W-1:0]   pow_reg, pow_next;
    logic [acm_pkg::SUM16_W-1:0] total_reg, total_next;
    logic                        out_valid_reg, out_valid_next;
    logic [acm_pkg::COST_W-1:0]  out_cost_reg, out_cost_next;
    logic [acm_pkg::ABS_W-1:0]   out_abs_reg, out_abs_next;
    logic [acm_pkg::CNT_W-1:0]   out_cnt_reg, out_cnt_next;

    logic [WW-1:0]                 mul_a, mul_b;
    logic [acm_pkg::PROD_W-1:0]    mul_p;
    logic                          div_start;
    logic [WW-1:0]                 div_dividend;
    logic [acm_pkg::IDX_W-1:0]     div_divisor;
    logic                          div_done;
    logic [WW-1:0]                 div_quot;
    logic [WW-1:0]                 series_sum;
    logic [acm_pkg::X_INT_W-1:0]   x_int;
    logic [acm_pkg::SUM16_W:0]     e_round;
    logic [acm_pkg::SUM16_W-1:0]   e14, e14_cap, cost_term;

    assign out_valid = out_valid_reg;
    assign out_cost  = out_cost_reg;
    assign out_abs   = out_abs_reg;
    assign out_count = out_cnt_reg;

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            acm_pkg::BK_SER_MUL: begin
                mul_a = term_reg;
                mul_b = y_reg;
            end
            acm_pkg::BK_X_MUL: begin
                if (phase_reg == acm_pkg::PH_AD) begin
                    mul_a = WW'(abs_reg);
                    mul_b = WW'(cfg.inv_lambda_ad);
                end else begin
                    mul_a = WW'(cnt_reg);
                    mul_b = WW'(cfg.inv_lambda_census);
                end
            end
            acm_pkg::BK_POW: begin
                mul_a = e_reg;
                mul_b = e1_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // shared divider: series term by its index, or ad exponent by three
    assign div_start    = (state_reg == acm_pkg::BK_SER_DGO) ||
                          (state_reg == acm_pkg::BK_X_DGO);
    assign div_dividend = (state_reg == acm_pkg::BK_X_DGO) ? WW'(x_reg) : term_reg;
    assign div_divisor  = (state_reg == acm_pkg::BK_X_DGO) ? acm_pkg::AD_DIVISOR : idx_reg;

    acm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // series accumulation: odd terms subtract with floor at zero, even terms add
    always_comb begin
        if (idx_reg[0]) begin
            series_sum = (sum_reg >= div_quot) ? sum_reg - div_quot : '0;
        end else begin
            series_sum = sum_reg + div_quot;
        end
    end

    // exponential to q0.14 and cost term
    always_comb begin
        x_int     = x_reg[acm_pkg::X_W-1:acm_pkg::X_FRAC_W];
        e_round   = (acm_pkg::SUM16_W + 1)'((WW + 1)'(e_reg) + (WW + 1)'(32'h8000) >> 16);
        e14       = e_round[acm_pkg::SUM16_W-1:0];
        e14_cap   = (e_round > {1'b0, acm_pkg::ONE_Q14}) ? acm_pkg::ONE_Q14 : e14;
        cost_term = acm_pkg::ONE_Q14 - e14_cap;
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        abs_next       = abs_reg;
        cnt_next       = cnt_reg;
        y_next         = y_reg;
        term_next      = term_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        e1_next        = e1_reg;
        e_next         = e_reg;
        x_next         = x_reg;
        pow_next       = pow_reg;
        total_next     = total_reg;
        out_cost_next  = out_cost_reg;
        out_abs_next   = out_abs_reg;
        out_cnt_next   = out_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        job_pop        = 1'b0;

        unique case (state_reg)
            acm_pkg::BK_IDLE: begin
                if (job_valid) begin
                    job_pop    = 1'b1;
                    abs_next   = job_data.abs_sum;
                    cnt_next   = job_data.count;
                    phase_next = acm_pkg::PH_E1;
                    total_next = '0;
                    y_next     = acm_pkg::ONE_Q30;
                    sum_next   = acm_pkg::ONE_Q30;
                    term_next  = acm_pkg::ONE_Q30;
                    idx_next   = acm_pkg::IDX_W'(1);
                    state_next = acm_pkg::BK_SER_MUL;
                end
            end
            acm_pkg::BK_SER_MUL: begin
                term_next  = mul_p[FW +: WW];
                state_next = acm_pkg::BK_SER_DGO;
            end
            acm_pkg::BK_SER_DGO: begin
                state_next = acm_pkg::BK_SER_DWAIT;
            end
            acm_pkg::BK_SER_DWAIT: begin
                if (div_done) begin
                    if (idx_reg == acm_pkg::SERIES_TERMS) begin
                        if (phase_reg == acm_pkg::PH_E1) begin
                            e1_next    = series_sum;
                            phase_next = acm_pkg::PH_AD;
                            state_next = acm_pkg::BK_X_MUL;
                        end else begin
                            e_next     = series_sum;
                            state_next = (pow_reg == '0) ? acm_pkg::BK_TERM : acm_pkg::BK_POW;
                        end
                    end else begin
                        sum_next   = series_sum;
                        term_next  = div_quot;
                        idx_next   = idx_reg + 1'b1;
                        state_next = acm_pkg::BK_SER_MUL;
                    end
                end
            end
            acm_pkg::BK_X_MUL: begin
                x_next     = mul_p[acm_pkg::X_W-1:0];
                state_next = (phase_reg == acm_pkg::PH_AD) ? acm_pkg::BK_X_DGO :
                             acm_pkg::BK_X_EVAL;
            end
            acm_pkg::BK_X_DGO: begin
                state_next = acm_pkg::BK_X_DWAIT;
            end
            acm_pkg::BK_X_DWAIT: begin
                if (div_done) begin
                    x_next     = div_quot[acm_pkg::X_W-1:0];
                    state_next = acm_pkg::BK_X_EVAL;
                end
            end
            acm_pkg::BK_X_EVAL: begin
                if (x_int >= acm_pkg::EXP_INT_LIMIT) begin
                    e_next     = '0;
                    state_next = acm_pkg::BK_TERM;
                end else begin
                    y_next     = WW'({x_reg[acm_pkg::X_FRAC_W-1:0], 14'b0});
                    pow_next   = x_int[acm_pkg::IDX_W-1:0];
                    sum_next   = acm_pkg::ONE_Q30;
                    term_next  = acm_pkg::ONE_Q30;
                    idx_next   = acm_pkg::IDX_W'(1);
                    state_next = acm_pkg::BK_SER_MUL;
                end
            end
            acm_pkg::BK_POW: begin
                e_next   = mul_p[FW +: WW];
                pow_next = pow_reg - 1'b1;
                if (pow_reg == acm_pkg::IDX_W'(1)) begin
                    state_next = acm_pkg::BK_TERM;
                end
            end
            acm_pkg::BK_TERM: begin
                total_next = total_reg + cost_term;
                if (phase_reg == acm_pkg::PH_AD) begin
                    phase_next = acm_pkg::PH_CEN;
                    state_next = acm_pkg::BK_X_MUL;
                end else begin
                    state_next = acm_pkg::BK_OUT;
                end
            end
            acm_pkg::BK_OUT: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    out_cost_next  = (total_reg > acm_pkg::COST_MAX) ?
                                     acm_pkg::COST_MAX[acm_pkg::COST_W-1:0] :
                                     total_reg[acm_pkg::COST_W-1:0];
                    out_abs_next   = abs_reg;
                    out_cnt_next   = cnt_reg;
                    state_next     = acm_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = acm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= acm_pkg::BK_IDLE;
            phase_reg     <= acm_pkg::PH_E1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        abs_reg      <= abs_next;
        cnt_reg      <= cnt_next;
        y_reg        <= y_next;
        term_reg     <= term_next;
        sum_reg      <= sum_next;
        idx_reg      <= idx_next;
        e1_reg       <= e1_next;
        e_reg        <= e_next;
        x_reg        <= x_next;
        pow_reg      <= pow_next;
        total_reg    <= total_next;
        out_cost_reg <= out_cost_next;
        out_abs_reg  <= out_abs_next;
        out_cnt_reg  <= out_cnt_next;
    end

    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == acm_pkg::BK_SER_DWAIT || state_reg == acm_pkg::BK_X_DWAIT))
        else $error("divider result arrived outside a wait state");

endmodule

`default_nettype wire

// ----- hw/rtl/ad_census_matching_cost.sv -----
`default_nettype none

// AD-Census matching cost. The front end takes one window pixel pair per cycle
// (s_tuser marks the centre reference pair that opens a group, s_tlast the pair
// that closes it), keeps the references, the centre abs difference sum and a
// saturating count of channels where left and right sit strictly on opposite
// sides of their references, and queues one job per closed group in a two-entry
// queue. The back end turns each job into a cost from the two exponentials,
// using one shared multiplier and a divider that multiplies by the reciprocal of
// the small divisor and registers its answer in the cycle after it starts. A job
// runs up to three 12-term series, each term a multiply and then a divide, and
// one multiply per whole unit of each exponent, plus setup and output and any
// wait on m_tready; an exponent of 12 or more skips its series and powers. Pairs
// keep streaming while a job runs until the queue is full. Write the lambda
// registers only while the block is idle.
module ad_census_matching_cost #(
    parameter int MAX_WINDOW_PIXELS = 81
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // s_tdata: left_red, left_green, left_blue, right_red, right_green, right_blue
    input  wire logic [acm_pkg::S_TDATA_W-1:0]       s_tdata,
    // s_tuser: first_pair
    input  wire logic                                s_tuser,
    input  wire logic                                s_tlast,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // m_tdata: combined_cost, abs_diff_sum, census_count, zero fill
    output logic [acm_pkg::M_TDATA_W-1:0]            m_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic                                cfg_we,
    input  wire logic [acm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [acm_pkg::LAMBDA_W-1:0]        cfg_wdata
);

    acm_pkg::cost_cfg_t cfg_reg, cfg_next;
    acm_pkg::cost_job_t push_data, pop_data;
    logic                        push, queue_full, pop, pop_valid;
    logic [acm_pkg::COST_W-1:0]  out_cost;
    logic [acm_pkg::ABS_W-1:0]   out_abs;
    logic [acm_pkg::CNT_W-1:0]   out_count;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                acm_pkg::REG_INV_LAMBDA_AD:     cfg_next.inv_lambda_ad     = cfg_wdata;
                acm_pkg::REG_INV_LAMBDA_CENSUS: cfg_next.inv_lambda_census = cfg_wdata;
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inv_lambda_ad     <= acm_pkg::INV_LAMBDA_AD_RESET;
            cfg_reg.inv_lambda_census <= acm_pkg::INV_LAMBDA_CENSUS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    acm_front #(
        .MAX_WINDOW_PIXELS (MAX_WINDOW_PIXELS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_first   (s_tuser),
        .in_last    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    acm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    acm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_valid (pop_valid),
        .job_data  (pop_data),
        .job_pop   (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_cost  (out_cost),
        .out_abs   (out_abs),
        .out_count (out_count)
    );

    // result beat packing
    assign m_tdata = {(acm_pkg::M_TDATA_W - acm_pkg::M_USED_W)'(0), out_count, out_abs, out_cost};

endmodule

`default_nettype wire

// ----- verif/tb_ad_census_matching_cost.sv -----
`timescale 1ns / 100ps

module tb_ad_census_matching_cost;

    import acm_pkg::*;

    // predictor constants
    localparam int          WINDOW_PIXELS = 81;
    localparam int          CENSUS_BOUND  = (3 * WINDOW_PIXELS > 255) ? 255 : 3 * WINDOW_PIXELS;
    localparam bit [63:0]   Q30_UNIT      = 64'd1 << 30;
    localparam int          SERIES_LEN    = 12;
    localparam bit [63:0]   EXP_CUTOFF    = 64'd12;
    localparam bit [63:0]   Q14_UNIT      = 64'd16384;
    localparam bit [15:0]   COST_CEIL     = 16'd32767;
    localparam bit [63:0]   AD_CHANNELS   = 64'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 4'd15;

    // run shape
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int QUIET_AFTER     = 1300;
    localparam int JOB_CYCLES      = 1300;
    localparam int LIMIT_CYCLES    = 8_000_000;
    localparam int MAX_REPORTS     = 200;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [ABS_W-1:0]  abs_sum;
        logic [CNT_W-1:0]  count;
    } cost_result_t;

    typedef enum logic [1:0] {
        ROW_BEAT,
        ROW_TYPED,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic                   first;
        logic                   last;
        logic [RGB_W-1:0]       lp;
        logic [RGB_W-1:0]       rp;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [LAMBDA_W-1:0]    reg_val;
        cost_result_t           want;
    } stim_row_t;

    // dut signals
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    // s_tdata: left_red, left_green, left_blue, right_red, right_green, right_blue
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    // s_tuser: first_pair
    logic                   s_tuser   = 1'b0;
    logic                   s_tlast   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // m_tdata: combined_cost, abs_diff_sum, census_count, zero fill
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_INV_LAMBDA_AD;
    logic [LAMBDA_W-1:0]    cfg_wdata = '0;

    // predictor state
    logic [RGB_W-1:0]    centre_left  = '0;
    logic [RGB_W-1:0]    centre_right = '0;
    logic [ABS_W-1:0]    centre_abs   = '0;
    logic [CNT_W-1:0]    census_cnt   = '0;
    logic [LAMBDA_W-1:0] inv_ad       = INV_LAMBDA_AD_RESET;
    logic [LAMBDA_W-1:0] inv_cen      = INV_LAMBDA_CENSUS_RESET;

    cost_result_t expected_costs[$];
    int           mismatches  = 0;
    int unsigned  cycle_count = 0;
    int           items_sent  = 0;
    int           stall_left  = 0;
    bit           gaps_on     = 1'b0;
    bit           stalls_on   = 1'b0;

    // directed rows: register writes between groups, typed results where obvious
    stim_row_t directed_rows [26] = '{
        // before any first pair: references are still zero
        '{ROW_BEAT,  1'b0, 1'b0, 24'h123456, 24'hABCDEF, '0, '0, '0},
        '{ROW_TYPED, 1'b0, 1'b1, 24'h00FF00, 24'hFF00FF, '0, '0, '{15'd0, 10'd0, 8'd0}},
        '{ROW_TYPED, 1'b1, 1'b1, 24'h000000, 24'h000000, '0, '0, '{15'd0, 10'd0, 8'd0}},
        // extremes as single-pair groups
        '{ROW_BEAT,  1'b1, 1'b1, 24'hFFFFFF, 24'h000000, '0, '0, '0},
        '{ROW_BEAT,  1'b1, 1'b1, 24'h000000, 24'hFFFFFF, '0, '0, '0},
        // opposite sides, ties, same side
        '{ROW_BEAT,  1'b1, 1'b0, 24'h808080, 24'h808080, '0, '0, '0},
        '{ROW_BEAT,  1'b0, 1'b0, 24'hFFFFFF, 24'h000000, '0, '0, '0},
        '{ROW_BEAT,  1'b0, 1'b0, 24'h000000, 24'hFFFFFF, '0, '0, '0},
        '{ROW_BEAT,  1'b0, 1'b0, 24'h808080, 24'h000000, '0, '0, '0},
        '{ROW_BEAT,  1'b0, 1'b0, 24'hFFFFFF, 24'hFFFFFF, '0, '0, '0},
        '{ROW_BEAT,  1'b0, 1'b1, 24'h7F8180, 24'h817F80, '0, '0, '0},
        // keeps accumulating after a last pair
        '{ROW_BEAT,  1'b0, 1'b1, 24'hFF00FF, 24'h00FF00, '0, '0, '0},
        // largest reciprocals
        '{ROW_REG,   1'b0, 1'b0, '0, '0, REG_INV_LAMBDA_AD,     16'hFFFF, '0},
        '{ROW_REG,   1'b0, 1'b0, '0, '0, REG_INV_LAMBDA_CENSUS, 16'hFFFF, '0},
        '{ROW_TYPED, 1'b1, 1'b1, 24'hFFFFFF, 24'h000000, '0, '0, '{15'd16384, 10'd765, 8'd0}},
        '{ROW_BEAT,  1'b1, 1'b0, 24'h808080, 24'h808080, '0, '0, '0},
        '{ROW_BEAT,  1'b0, 1'b1, 24'h000000, 24'hFFFFFF, '0, '0, '0},
        // smallest nonzero reciprocals
        '{ROW_REG,   1'b0, 1'b0, '0, '0, REG_INV_LAMBDA_AD,     16'h0001, '0},
        '{ROW_REG,   1'b0, 1'b0, '0, '0, REG_INV_LAMBDA_CENSUS, 16'h0001, '0},
        '{ROW_BEAT,  1'b1, 1'b1, 24'hFFFFFF, 24'h000000, '0, '0, '0},
        // zero reciprocals, then a write to an unmapped index that must not land
        '{ROW_REG,   1'b0, 1'b0, '0, '0, REG_INV_LAMBDA_AD,     16'h0000, '0},
        '{ROW_REG,   1'b0, 1'b0, '0, '0, REG_INV_LAMBDA_CENSUS, 16'h0000, '0},
        '{ROW_REG,   1'b0, 1'b0, '0, '0, REG_UNMAPPED,          16'hFFFF, '0},
        '{ROW_TYPED, 1'b1, 1'b1, 24'hFFFFFF, 24'h000000, '0, '0, '{15'd0, 10'd765, 8'd0}},
        '{ROW_BEAT,  1'b1, 1'b0, 24'h808080, 24'h808080, '0, '0, '0},
        '{ROW_TYPED, 1'b0, 1'b1, 24'h000000, 24'hFFFFFF, '0, '0, '{15'd0, 10'd0, 8'd3}}
    };

    ad_census_matching_cost uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // exp(-y), y in Q0.30 up to one, by alternating series
    function automatic bit [63:0] exp_neg_q30(input bit [63:0] y);
        bit [63:0] acc;
        bit [63:0] term;
        int        i;
        acc  = Q30_UNIT;
        term = Q30_UNIT;
        for (i = 1; i <= SERIES_LEN; i++) begin
            term = ((term * y) >> 30) / 64'(i);
            if (i[0])
                acc = (acc >= term) ? acc - term : 64'd0;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

    // 1 - exp(-x), x in Q.16, result in Q0.14
    function automatic bit [15:0] one_minus_exp(input bit [63:0] x);
        bit [63:0] whole;
        bit [63:0] e;
        bit [63:0] e_unit;
        bit [63:0] e14;
        int        k;
        whole = x >> 16;
        e     = 64'd0;
        if (whole < EXP_CUTOFF) begin
            e_unit = exp_neg_q30(Q30_UNIT);
            e      = exp_neg_q30((x & 64'hFFFF) << 14);
            for (k = 0; k < int'(whole); k++)
                e = (e * e_unit) >> 30;
        end
        e14 = (e + 64'h8000) >> 16;
        if (e14 > Q14_UNIT)
            e14 = Q14_UNIT;
        return 16'(Q14_UNIT - e14);
    endfunction

    // one accepted pair: update window state, return 1 with the cost on a last pair
    function automatic bit census_cost_step(input logic first, input logic last,
                                            input logic [RGB_W-1:0] lp,
                                            input logic [RGB_W-1:0] rp,
                                            output cost_result_t res);
        logic [PIX_W-1:0] l, r, lc, rc;
        logic [ABS_W-1:0] s;
        bit   [15:0]      total;
        int               ch;
        res = '0;
        if (first) begin
            centre_left  = lp;
            centre_right = rp;
            s = '0;
            for (ch = 0; ch < 3; ch++) begin
                l = lp[PIX_W*ch +: PIX_W];
                r = rp[PIX_W*ch +: PIX_W];
                s = s + ((l > r) ? l - r : r - l);
            end
            centre_abs = s;
            census_cnt = '0;
        end
        for (ch = 0; ch < 3; ch++) begin
            l  = lp[PIX_W*ch +: PIX_W];
            r  = rp[PIX_W*ch +: PIX_W];
            lc = centre_left[PIX_W*ch +: PIX_W];
            rc = centre_right[PIX_W*ch +: PIX_W];
            if (((l < lc && r > rc) || (l > lc && r < rc)) && census_cnt < CENSUS_BOUND)
                census_cnt = census_cnt + 1'b1;
        end
        if (!last)
            return 1'b0;
        total = one_minus_exp((64'(centre_abs) * 64'(inv_ad)) / AD_CHANNELS)
              + one_minus_exp(64'(census_cnt) * 64'(inv_cen));
        if (total > COST_CEIL)
            total = COST_CEIL;
        res.cost    = total[COST_W-1:0];
        res.abs_sum = centre_abs;
        res.count   = census_cnt;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_REPORTS)
            $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        mismatches++;
    endtask

    // one beat on the pair channel, with an optional gap before it
    task automatic push_pair(input logic first, input logic last,
                             input logic [RGB_W-1:0] lp, input logic [RGB_W-1:0] rp,
                             input bit typed, input cost_result_t want);
        cost_result_t predicted;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tdata  <= {rp, lp};
        s_tuser  <= first;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (census_cost_step(first, last, lp, rp, predicted))
            expected_costs.push_back(typed ? want : predicted);
        items_sent++;
        @(negedge aclk);
    endtask

    // register write once the block has drained
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [LAMBDA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (expected_costs.size() != 0) @(negedge aclk);
        repeat (JOB_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_INV_LAMBDA_AD)
            inv_ad = val;
        else if (idx == REG_INV_LAMBDA_CENSUS)
            inv_cen = val;
    endtask

    // channel level biased toward the ends of the range
    function automatic logic [PIX_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // window pixel around a centre pixel, sometimes tying a channel
    function automatic logic [RGB_W-1:0] near_pixel(input logic [RGB_W-1:0] centre_px);
        logic [RGB_W-1:0] px;
        int               ch;
        for (ch = 0; ch < 3; ch++)
            px[PIX_W*ch +: PIX_W] = ($urandom_range(0, 5) == 0) ? centre_px[PIX_W*ch +: PIX_W]
                                                                : pick_level();
        return px;
    endfunction

    // window where every channel disagrees, long enough to saturate the count
    task automatic send_opposite_window(input int pairs);
        logic [RGB_W-1:0] lc, rc, lp, rp;
        int               j, ch, lo_l, lo_r;
        for (ch = 0; ch < 3; ch++) begin
            lc[PIX_W*ch +: PIX_W] = 8'($urandom_range(1, 254));
            rc[PIX_W*ch +: PIX_W] = 8'($urandom_range(1, 254));
        end
        push_pair(1'b1, 1'b0, lc, rc, 1'b0, '0);
        for (j = 1; j < pairs; j++) begin
            for (ch = 0; ch < 3; ch++) begin
                lo_l = int'(lc[PIX_W*ch +: PIX_W]);
                lo_r = int'(rc[PIX_W*ch +: PIX_W]);
                if ($urandom_range(0, 1)) begin
                    lp[PIX_W*ch +: PIX_W] = 8'($urandom_range(0, lo_l - 1));
                    rp[PIX_W*ch +: PIX_W] = 8'($urandom_range(lo_r + 1, 255));
                end else begin
                    lp[PIX_W*ch +: PIX_W] = 8'($urandom_range(lo_l + 1, 255));
                    rp[PIX_W*ch +: PIX_W] = 8'($urandom_range(0, lo_r - 1));
                end
            end
            push_pair(1'b0, j == pairs - 1, lp, rp, 1'b0, '0);
        end
    endtask

    // well-formed window with random content, sometimes left open
    task automatic send_window_group(input int pairs);
        logic [RGB_W-1:0] lc, rc;
        bit               close;
        int               j, ch;
        for (ch = 0; ch < 3; ch++) begin
            lc[PIX_W*ch +: PIX_W] = pick_level();
            rc[PIX_W*ch +: PIX_W] = pick_level();
        end
        close = $urandom_range(0, 9) != 0;
        push_pair(1'b1, close && pairs == 1, lc, rc, 1'b0, '0);
        for (j = 1; j < pairs; j++)
            push_pair(1'b0, close && j == pairs - 1, near_pixel(lc), near_pixel(rc), 1'b0, '0);
    endtask

    // result stall bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result beat check against the oldest expected cost
    always @(posedge aclk) begin : result_check
        cost_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_costs.size() == 0) begin
                report_mismatch("result with nothing pending", int'(m_tdata[COST_W-1:0]), 0);
            end else begin
                want = expected_costs.pop_front();
                if (m_tdata[COST_W-1:0] !== want.cost)
                    report_mismatch("combined_cost", int'(m_tdata[COST_W-1:0]), int'(want.cost));
                if (m_tdata[COST_W +: ABS_W] !== want.abs_sum)
                    report_mismatch("abs_diff_sum", int'(m_tdata[COST_W +: ABS_W]),
                                    int'(want.abs_sum));
                if (m_tdata[COST_W+ABS_W +: CNT_W] !== want.count)
                    report_mismatch("census_count", int'(m_tdata[COST_W+ABS_W +: CNT_W]),
                                    int'(want.count));
                if (m_tdata[M_TDATA_W-1:M_USED_W] !== '0)
                    report_mismatch("zero fill", int'(m_tdata[M_TDATA_W-1:M_USED_W]), 0);
            end
        end
    end

    // main sequence
    initial begin
        stim_row_t           row;
        logic [LAMBDA_W-1:0] ad_val, cen_val;
        int                  phase, phase_start, pick;
        bit                  quiet;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
                write_reg(row.reg_idx, row.reg_val);
            else
                push_pair(row.first, row.last, row.lp, row.rp, row.kind == ROW_TYPED, row.want);
        end

        // random phases, each under its own register setting
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin ad_val = INV_LAMBDA_AD_RESET; cen_val = INV_LAMBDA_CENSUS_RESET; end
                1: begin ad_val = 16'hFFFF; cen_val = 16'hFFFF; end
                2: begin ad_val = 16'h0001; cen_val = 16'h0001; end
                4: begin
                    ad_val  = 16'($urandom_range(1, 4096));
                    cen_val = 16'($urandom_range(1, 4096));
                end
                default: begin
                    ad_val  = 16'($urandom_range(1, 65535));
                    cen_val = 16'($urandom_range(1, 65535));
                end
            endcase
            write_reg(REG_INV_LAMBDA_AD, ad_val);
            write_reg(REG_INV_LAMBDA_CENSUS, cen_val);
            phase_start = items_sent;
            if (phase == 1 || phase == 3)
                send_opposite_window($urandom_range(84, 92));
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                quiet     = items_sent >= QUIET_AFTER;
                gaps_on   = !quiet && $urandom_range(0, 2) != 0;
                stalls_on = !quiet && $urandom_range(0, 2) != 0;
                pick      = $urandom_range(0, 99);
                if (pick < 3)
                    send_opposite_window($urandom_range(84, 92));
                else if (pick < 18)
                    push_pair(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              24'($urandom), 24'($urandom), 1'b0, '0);
                else
                    send_window_group($urandom_range(1, 16));
            end
        end

        // drain and finish
        s_tvalid  <= 1'b0;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        while (expected_costs.size() != 0) @(negedge aclk);
        repeat (JOB_CYCLES) @(negedge aclk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/acm_pkg.sv
hw/rtl/acm_queue.sv
hw/rtl/acm_front.sv
hw/rtl/acm_div.sv
hw/rtl/acm_back.sv
hw/rtl/ad_census_matching_cost.sv
verif/tb_ad_census_matching_cost.sv
